[sv/whsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whsp_pkg
// shared types and constants of the wav header stream parser
// ----------------------------------------------------------------------------
package whsp_pkg;

   localparam int SyncLen = 12;
   localparam int FmtLen  = 16;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FORMAT_PCM = 16'd1;

   // result status codes
   localparam logic [2:0] ST_SEEK    = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_DONE    = 3'd2;
   localparam logic [2:0] ST_PAYLOAD = 3'd3;
   localparam logic [2:0] ST_ERROR   = 3'd4;

   typedef enum logic [5:0] {
      PH_SEEK = 6'b000001,
      PH_HDR  = 6'b000010,
      PH_FMT  = 6'b000100,
      PH_SKIP = 6'b001000,
      PH_DATA = 6'b010000,
      PH_ERR  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  payload_byte;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
   } result_type;

endpackage

[sv/wav_header_stream_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_stream_parser
// byte-wide riff/wave header parser with pcm format capture and pass-through
// ----------------------------------------------------------------------------
// One byte enters per req transfer and exactly one result leaves per rsp
// transfer. The block hunts for "RIFF", four size bytes and "WAVE", walks the
// chunk headers, captures the first 16 bytes of the fmt chunk, skips every
// other chunk with its pad byte, and after the data chunk header passes each
// byte through with status 3. A short fmt chunk, a non-pcm format tag or a
// data chunk without a usable format gives a sticky error (status 4) until
// reset. Throughput is one byte per clock: the whole per-byte decision is a
// single step of the parser state, and the result sits in an output register
// backed by a one-entry skid buffer, so req_tready only drops when the
// consumer has stalled for two results.
module wav_header_stream_parser (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // [7:0] payload_byte, [23:8] channels,
                                     // [55:24] sample_rate, [87:56] byte_rate,
                                     // [103:88] block_align,
                                     // [119:104] bits_per_sample
   output logic [2:0]   rsp_tuser    // [2:0] status
);
   import whsp_pkg::*;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  window_ff [SyncLen];
   logic [7:0]  window_in [SyncLen];
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] skip_ff, skip_in;
   logic [7:0]  fmt_ff [FmtLen];
   logic [7:0]  fmt_in [FmtLen];
   logic        fmt_seen_ff, fmt_seen_in;

   // output register and skid
   result_type  out_ff, skid_ff, result;
   logic        out_valid_ff, skid_valid_ff;

   logic        accept;
   logic        out_take;
   logic [7:0]  b;
   logic [2:0]  status;
   logic [7:0]  payload;
   logic [32:0] skip_amount;
   logic [31:0] fmt_rest;

   assign b          = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_take   = !out_valid_ff || rsp_tready;

   // per-byte step of the parser
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      skip_in     = skip_ff;
      fmt_seen_in = fmt_seen_ff;
      status      = ST_HEADER;
      payload     = 8'd0;
      skip_amount = 33'd0;
      fmt_rest    = len_ff - 32'(FmtLen);
      for (int k = 0; k < SyncLen; k++) window_in[k] = window_ff[k];
      for (int k = 0; k < FmtLen; k++) fmt_in[k] = fmt_ff[k];

      unique case (phase_ff)
         PH_SEEK: begin
            for (int k = 0; k < SyncLen - 1; k++) window_in[k] = window_ff[k + 1];
            window_in[SyncLen - 1] = b;
            if ({window_in[0], window_in[1], window_in[2], window_in[3]} == TAG_RIFF &&
                {window_in[8], window_in[9], window_in[10], window_in[11]} == TAG_WAVE) begin
               phase_in   = PH_HDR;
               hdr_idx_in = 4'd0;
               status     = ST_HEADER;
            end else begin
               status = ST_SEEK;
            end
         end
         PH_HDR: begin
            // tag bytes first, then a little-endian length
            if (!hdr_idx_ff[2]) begin
               tag_in = {tag_ff[23:0], b};
            end else begin
               len_in = {b, len_ff[31:8]};
            end
            hdr_idx_in = {1'b0, hdr_idx_ff[2:0]} + 4'd1;
            if (hdr_idx_ff[2:0] == 3'd7) begin
               hdr_idx_in = 4'd0;
               if (tag_ff == TAG_DATA) begin
                  if (fmt_seen_ff && {fmt_ff[13], fmt_ff[12]} != 16'd0) begin
                     phase_in = PH_DATA;
                     status   = ST_DONE;
                  end else begin
                     phase_in = PH_ERR;
                     status   = ST_ERROR;
                  end
               end else if (tag_ff == TAG_FMT) begin
                  if (len_in < 32'(FmtLen)) begin
                     phase_in = PH_ERR;
                     status   = ST_ERROR;
                  end else begin
                     phase_in = PH_FMT;
                  end
               end else begin
                  // skip body plus pad byte of an odd length
                  skip_amount = {1'b0, len_in} + {32'd0, len_in[0]};
                  skip_in     = skip_amount;
                  phase_in    = (skip_amount != 33'd0) ? PH_SKIP : PH_HDR;
               end
            end
         end
         PH_FMT: begin
            fmt_in[hdr_idx_ff] = b;
            hdr_idx_in = hdr_idx_ff + 4'd1;
            if (hdr_idx_ff == 4'(FmtLen - 1)) begin
               if ({fmt_in[1], fmt_in[0]} != FORMAT_PCM) begin
                  fmt_seen_in = 1'b0;
                  phase_in    = PH_ERR;
                  status      = ST_ERROR;
               end else begin
                  fmt_seen_in = 1'b1;
                  skip_amount = {1'b0, fmt_rest} + {32'd0, len_ff[0]};
                  skip_in     = skip_amount;
                  hdr_idx_in  = 4'd0;
                  phase_in    = (skip_amount != 33'd0) ? PH_SKIP : PH_HDR;
               end
            end
         end
         PH_SKIP: begin
            if (skip_ff != 33'd0) skip_in = skip_ff - 33'd1;
            if (skip_in == 33'd0) begin
               phase_in   = PH_HDR;
               hdr_idx_in = 4'd0;
            end
         end
         PH_DATA: begin
            status  = ST_PAYLOAD;
            payload = b;
         end
         default: begin
            // error phase and unused codes hold everything
            status = ST_ERROR;
         end
      endcase

      result.status          = status;
      result.payload_byte    = payload;
      result.channels        = {fmt_in[3], fmt_in[2]};
      result.sample_rate     = {fmt_in[7], fmt_in[6], fmt_in[5], fmt_in[4]};
      result.byte_rate       = {fmt_in[11], fmt_in[10], fmt_in[9], fmt_in[8]};
      result.block_align     = {fmt_in[13], fmt_in[12]};
      result.bits_per_sample = {fmt_in[15], fmt_in[14]};
   end

   // parser state registers, updated on each req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEEK;
         hdr_idx_ff  <= 4'd0;
         tag_ff      <= 32'd0;
         len_ff      <= 32'd0;
         skip_ff     <= 33'd0;
         fmt_seen_ff <= 1'b0;
         for (int k = 0; k < SyncLen; k++) window_ff[k] <= 8'd0;
         for (int k = 0; k < FmtLen; k++) fmt_ff[k] <= 8'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         fmt_seen_ff <= fmt_seen_in;
         for (int k = 0; k < SyncLen; k++) window_ff[k] <= window_in[k];
         for (int k = 0; k < FmtLen; k++) fmt_ff[k] <= fmt_in[k];
      end
   end

   // output register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         // output slot frees up: refill from skid first, else from new result
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (accept && !out_take) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {out_ff.bits_per_sample, out_ff.block_align, out_ff.byte_rate,
                        out_ff.sample_rate, out_ff.channels, out_ff.payload_byte};

`ifndef NO_ASSERTIONS
   // the skid only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // error is sticky
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |=> phase_ff == PH_ERR)
      else $error("parser left the error phase without reset");

   // skip phase always has bytes left to drop
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 33'd0)
      else $error("skip phase with nothing to skip");

   // payload lane is zero unless the result is a payload byte
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != ST_PAYLOAD |-> out_ff.payload_byte == 8'd0)
      else $error("payload byte set on a non-payload result");
`endif

endmodule
